@@ design/spc_pkg.sv @@
package spc_pkg;

  typedef struct packed {
    logic signed [15:0] log_scale_x;
    logic signed [15:0] log_scale_y;
    logic signed [15:0] log_scale_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } splat_t;

  typedef struct packed {
    logic signed [47:0] cov_xx;
    logic signed [47:0] cov_xy;
    logic signed [47:0] cov_xz;
    logic signed [47:0] cov_yy;
    logic signed [47:0] cov_yz;
    logic signed [47:0] cov_zz;
  } cov_t;

  typedef struct packed {
    logic qx;
    logic qy;
    logic qz;
  } flip_t;

  // Rotation entries Q1.30, row major; scales Q12.20
  typedef logic [8:0][31:0] rot_mat_t;
  typedef logic [2:0][31:0] scale_vec_t;

  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_NEGATE_QX = 2'd0;
  localparam logic [1:0] REG_NEGATE_QY = 2'd1;
  localparam logic [1:0] REG_NEGATE_QZ = 2'd2;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [31:0] Q30_ONE   = 32'h4000_0000;
  localparam int EXP_TERMS = 10;
  // floor((2^32 - 1) / k) for k = 1 .. EXP_TERMS
  localparam logic [31:0] RECIP_K [EXP_TERMS] = '{
    32'd4294967295, 32'd2147483647, 32'd1431655765, 32'd1073741823, 32'd858993459,
    32'd715827882,  32'd613566756,  32'd536870911,  32'd477218588,  32'd429496729
  };

  localparam int DIV_STEPS = 31;
  localparam int ROT_LAT   = DIV_STEPS + 5;
  localparam int EXP_LAT   = 3 * EXP_TERMS + 3;
  localparam int COV_LAT   = 5;
  localparam int PIPE_LAT  = ROT_LAT + COV_LAT;

  localparam int PAIR_ROW [6] = '{0, 0, 0, 1, 1, 2};
  localparam int PAIR_COL [6] = '{0, 1, 2, 1, 2, 2};

endpackage

@@ design/spc_exp.sv @@
module spc_exp (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] log_scale,
  output logic [31:0]        scale
);
  import spc_pkg::*;

  localparam logic signed [46:0] LOG2E_S = 47'(LOG2E_Q30);

  logic signed [46:0] y;
  logic [31:0]        va [EXP_TERMS];
  logic [29:0]        za [EXP_TERMS];
  logic signed [4:0]  na [EXP_TERMS];
  logic [31:0]        qb [EXP_TERMS];
  logic [31:0]        vb [EXP_TERMS];
  logic [29:0]        zb [EXP_TERMS];
  logic signed [4:0]  nb [EXP_TERMS];
  logic [31:0]        pc [EXP_TERMS+1];
  logic [29:0]        zc [EXP_TERMS+1];
  logic signed [4:0]  nc [EXP_TERMS+1];

  always_ff @(posedge clk) begin
    logic [59:0] zp;
    logic [61:0] vp;
    logic [63:0] qp;
    logic [35:0] rem;
    logic [31:0] qn;
    logic signed [5:0] sh;
    if (en) begin
      y <= 47'(log_scale) * LOG2E_S;

      // split into integer part and ln2-scaled fraction
      zp = 60'(y[41:12]) * 60'(LN2_Q30);
      zc[0] <= zp[59:30];
      nc[0] <= y[46:42];
      pc[0] <= Q30_ONE;

      // Horner steps, k counts down from EXP_TERMS
      for (int i = 0; i < EXP_TERMS; i++) begin
        vp = 62'(zc[i]) * 62'(pc[i]);
        va[i] <= vp[61:30];
        za[i] <= zc[i];
        na[i] <= nc[i];

        qp = 64'(va[i]) * 64'(RECIP_K[EXP_TERMS-1-i]);
        qb[i] <= qp[63:32];
        vb[i] <= va[i];
        zb[i] <= za[i];
        nb[i] <= na[i];

        rem = 36'(vb[i]) - 36'(qb[i]) * 36'(EXP_TERMS - i);
        qn  = (rem >= 36'(EXP_TERMS - i)) ? qb[i] + 32'd1 : qb[i];
        pc[i+1] <= Q30_ONE + qn;
        zc[i+1] <= zb[i];
        nc[i+1] <= nb[i];
      end

      sh = 6'(nc[EXP_TERMS]) - 6'sd10;
      if (!sh[5]) begin
        scale <= pc[EXP_TERMS] << sh[0];
      end else begin
        scale <= pc[EXP_TERMS] >> 5'(-sh);
      end
    end
  end

endmodule

@@ design/spc_rot.sv @@
module spc_rot (
  input  logic              clk,
  input  logic              en,
  input  spc_pkg::splat_t   splat,
  input  spc_pkg::flip_t    flip,
  output spc_pkg::rot_mat_t rot
);
  import spc_pkg::*;

  logic signed [16:0] qw, qx, qy, qz;
  logic signed [33:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
  logic signed [34:0] a [9];
  logic [32:0]        n2a;
  logic               za;

  logic [32:0] rem [DIV_STEPS+1][9];
  logic [30:0] dl  [DIV_STEPS+1][9];
  logic [30:0] qt  [DIV_STEPS+1][9];
  logic        sg  [DIV_STEPS+1][9];
  logic [32:0] n2s [DIV_STEPS+1];
  logic        zs  [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    logic [34:0] mag;
    logic [63:0] d;
    logic [33:0] tr;
    logic        ge;
    if (en) begin
      qw <= 17'(splat.quat_w);
      qx <= flip.qx ? -17'(splat.quat_x) : 17'(splat.quat_x);
      qy <= flip.qy ? -17'(splat.quat_y) : 17'(splat.quat_y);
      qz <= flip.qz ? -17'(splat.quat_z) : 17'(splat.quat_z);

      ww <= 34'(qw) * 34'(qw);
      xx <= 34'(qx) * 34'(qx);
      yy <= 34'(qy) * 34'(qy);
      zz <= 34'(qz) * 34'(qz);
      xy <= 34'(qx) * 34'(qy);
      wz <= 34'(qw) * 34'(qz);
      xz <= 34'(qx) * 34'(qz);
      wy <= 34'(qw) * 34'(qy);
      yz <= 34'(qy) * 34'(qz);
      wx <= 34'(qw) * 34'(qx);

      a[0] <= 35'(ww) + 35'(xx) - 35'(yy) - 35'(zz);
      a[1] <= (35'(xy) - 35'(wz)) <<< 1;
      a[2] <= (35'(xz) + 35'(wy)) <<< 1;
      a[3] <= (35'(xy) + 35'(wz)) <<< 1;
      a[4] <= 35'(ww) - 35'(xx) + 35'(yy) - 35'(zz);
      a[5] <= (35'(yz) - 35'(wx)) <<< 1;
      a[6] <= (35'(xz) - 35'(wy)) <<< 1;
      a[7] <= (35'(yz) + 35'(wx)) <<< 1;
      a[8] <= 35'(ww) - 35'(xx) - 35'(yy) + 35'(zz);
      n2a  <= 33'(35'(ww) + 35'(xx) + 35'(yy) + 35'(zz));
      za   <= (35'(ww) + 35'(xx) + 35'(yy) + 35'(zz)) == 35'sd0;

      // dividend |A| * 2^30 + n2/2, magnitude never exceeds n2
      for (int j = 0; j < 9; j++) begin
        mag = a[j][34] ? 35'(-a[j]) : 35'(a[j]);
        d   = {1'b0, mag[32:0], 30'b0} + 64'(n2a >> 1);
        rem[0][j] <= d[63:31];
        dl[0][j]  <= d[30:0];
        qt[0][j]  <= '0;
        sg[0][j]  <= a[j][34];
      end
      n2s[0] <= n2a;
      zs[0]  <= za;

      // one restoring quotient bit per stage
      for (int t = 1; t <= DIV_STEPS; t++) begin
        for (int j = 0; j < 9; j++) begin
          tr = {rem[t-1][j], dl[t-1][j][30]};
          ge = tr >= {1'b0, n2s[t-1]};
          rem[t][j] <= ge ? 33'(tr - {1'b0, n2s[t-1]}) : tr[32:0];
          dl[t][j]  <= dl[t-1][j] << 1;
          qt[t][j]  <= {qt[t-1][j][29:0], ge};
          sg[t][j]  <= sg[t-1][j];
        end
        n2s[t] <= n2s[t-1];
        zs[t]  <= zs[t-1];
      end

      // zero-length quaternion gives the identity
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          if (zs[DIV_STEPS]) begin
            rot[3*i+k] <= (i == k) ? Q30_ONE : 32'd0;
          end else if (sg[DIV_STEPS][3*i+k]) begin
            rot[3*i+k] <= 32'd0 - 32'(qt[DIV_STEPS][3*i+k]);
          end else begin
            rot[3*i+k] <= 32'(qt[DIV_STEPS][3*i+k]);
          end
        end
      end
    end
  end

endmodule

@@ design/spc_cov.sv @@
module spc_cov (
  input  logic                clk,
  input  logic                en,
  input  spc_pkg::rot_mat_t   rot,
  input  spc_pkg::scale_vec_t scale,
  output spc_pkg::cov_t       cov
);
  import spc_pkg::*;

  logic [62:0]        pm [9];
  logic               ps [9];
  logic signed [31:0] m  [9];
  logic signed [63:0] pp [6][3];
  logic signed [63:0] sum [6];
  logic signed [47:0] c  [6];

  always_ff @(posedge clk) begin
    logic [31:0] rm;
    logic [63:0] mr;
    logic [63:0] mg;
    logic [51:0] rr;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          rm = rot[3*i+k][31] ? 32'd0 - rot[3*i+k] : rot[3*i+k];
          pm[3*i+k] <= 63'(rm[30:0]) * 63'(scale[k]);
          ps[3*i+k] <= rot[3*i+k][31];
        end
      end

      for (int j = 0; j < 9; j++) begin
        mr = 64'(pm[j]) + 64'h8000_0000;
        m[j] <= ps[j] ? 32'd0 - mr[63:32] : mr[63:32];
      end

      for (int e = 0; e < 6; e++) begin
        for (int k = 0; k < 3; k++) begin
          pp[e][k] <= 64'(m[3*PAIR_ROW[e]+k]) * 64'(m[3*PAIR_COL[e]+k]);
        end
      end

      for (int e = 0; e < 6; e++) begin
        sum[e] <= pp[e][0] + pp[e][1] + pp[e][2];
      end

      // round half away from zero to Q24.24, then saturate
      for (int e = 0; e < 6; e++) begin
        mg = sum[e][63] ? 64'd0 - sum[e] : sum[e];
        rr = 52'((mg + 64'd2048) >> 12);
        if (sum[e][63]) begin
          c[e] <= (rr > 52'h8000_0000_0000) ? 48'h8000_0000_0000 : 48'd0 - rr[47:0];
        end else begin
          c[e] <= (rr > 52'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : rr[47:0];
        end
      end
    end
  end

  assign cov.cov_xx = c[0];
  assign cov.cov_xy = c[1];
  assign cov.cov_xz = c[2];
  assign cov.cov_yy = c[3];
  assign cov.cov_yz = c[4];
  assign cov.cov_zz = c[5];

endmodule

@@ design/gaussian_splat_covariance.sv @@
// Splat covariance unit: log scales and rotation quaternion in, the six
// distinct entries of the 3x3 covariance out.
// Input channel splat_valid/splat_stall/splat carries one splat per request;
// output channel cov_valid/cov_stall/cov carries one covariance per request.
// A request is taken at a clock edge with valid high and stall low.
// One request is taken every cycle while splat_stall is low. The pipeline
// length is set by the 31-stage restoring divider that normalises the
// rotation.
// A two-entry output buffer follows the pipeline: a waiting result does not
// hold up the input; splat_stall rises only once both entries are full,
// and then the whole pipeline holds its contents until one is taken.
// Configuration (negate_qx/qy/qz at byte addresses 0, 4, 8) goes through the
// APB port; pready is always high; write only while no request is in flight.
// Synchronous reset empties the pipeline and the buffer and sets the flip
// registers to x kept, y and z negated.
module gaussian_splat_covariance (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        splat_valid,
  output logic                        splat_stall,
  input  spc_pkg::splat_t             splat,
  output logic                        cov_valid,
  input  logic                        cov_stall,
  output spc_pkg::cov_t               cov,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import spc_pkg::*;

  flip_t       flip;
  logic        en;
  logic        vld [PIPE_LAT];
  scale_vec_t  s_raw;
  scale_vec_t  s_dly [ROT_LAT-EXP_LAT];
  rot_mat_t    rot;
  cov_t        cov_pipe;
  cov_t        buf_mem [2];
  logic        wptr, rptr;
  logic [1:0]  cnt, cnt_next;
  logic        push, pop;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      flip <= '{qx: 1'b0, qy: 1'b1, qz: 1'b1};
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_NEGATE_QX: flip.qx <= pwdata[0];
        REG_NEGATE_QY: flip.qy <= pwdata[0];
        REG_NEGATE_QZ: flip.qz <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_NEGATE_QX: prdata = {31'b0, flip.qx};
      REG_NEGATE_QY: prdata = {31'b0, flip.qy};
      REG_NEGATE_QZ: prdata = {31'b0, flip.qz};
      default:       prdata = '0;
    endcase
  end

  // advance while the output buffer has room
  assign en          = cnt != 2'd2;
  assign splat_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < PIPE_LAT; t++) begin
        vld[t] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= splat_valid;
      for (int t = 1; t < PIPE_LAT; t++) begin
        vld[t] <= vld[t-1];
      end
    end
  end

  spc_exp u_exp_x (.clk(clk), .en(en), .log_scale(splat.log_scale_x), .scale(s_raw[0]));
  spc_exp u_exp_y (.clk(clk), .en(en), .log_scale(splat.log_scale_y), .scale(s_raw[1]));
  spc_exp u_exp_z (.clk(clk), .en(en), .log_scale(splat.log_scale_z), .scale(s_raw[2]));

  // line the scales up with the rotation
  always_ff @(posedge clk) begin
    if (en) begin
      s_dly[0] <= s_raw;
      for (int t = 1; t < ROT_LAT - EXP_LAT; t++) begin
        s_dly[t] <= s_dly[t-1];
      end
    end
  end

  spc_rot u_rot (.clk(clk), .en(en), .splat(splat), .flip(flip), .rot(rot));

  spc_cov u_cov (
    .clk   (clk),
    .en    (en),
    .rot   (rot),
    .scale (s_dly[ROT_LAT-EXP_LAT-1]),
    .cov   (cov_pipe)
  );

  assign push = en && vld[PIPE_LAT-1];
  assign pop  = cov_valid && !cov_stall;

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) begin
      cnt_next = cnt + 2'd1;
    end else if (pop && !push) begin
      cnt_next = cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      wptr <= 1'b0;
      rptr <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_mem[wptr] <= cov_pipe;
    end
  end

  assign cov_valid = cnt != 2'd0;
  assign cov       = buf_mem[rptr];

endmodule

@@ design/spc_chk.sv @@
module spc_chk (
  input logic          clk,
  input logic          rst,
  input logic          splat_stall,
  input logic          cov_valid,
  input logic          cov_stall,
  input spc_pkg::cov_t cov,
  input logic          pready
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    cov_valid && cov_stall |=> cov_valid)
    else $error("cov_valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    cov_valid && cov_stall |=> $stable(cov))
    else $error("cov changed while stalled");

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !cov_valid |-> !splat_stall)
    else $error("input stalled with empty output");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !cov_valid && pready)
    else $error("output not empty after reset");

endmodule

bind gaussian_splat_covariance spc_chk u_spc_chk (
  .clk         (clk),
  .rst         (rst),
  .splat_stall (splat_stall),
  .cov_valid   (cov_valid),
  .cov_stall   (cov_stall),
  .cov         (cov),
  .pready      (pready)
);

@@ bench/cov_checker.sv @@
module cov_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        splat_valid,
  input  logic                        splat_stall,
  input  spc_pkg::splat_t             splat,
  input  logic                        cov_valid,
  input  logic                        cov_stall,
  input  spc_pkg::cov_t               cov,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [spc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output int                          errors,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import spc_pkg::*;

  localparam longint ONE_Q30 = 64'sd1 <<< 30;
  localparam longint LOG2E   = 64'sd1549082005;
  localparam longint LN2     = 64'sd744261118;
  localparam longint POS_SAT = (64'sd1 <<< 47) - 1;
  localparam longint NEG_SAT = 64'sd1 <<< 47;

  flip_t flips;
  cov_t  cov_q[$];

  function automatic longint mag(input longint v);
    return v < 0 ? -v : v;
  endfunction

  // Q4.12 log scale to Q12.20 scale via base-2 split and Taylor series
  function automatic longint exp_scale(input logic signed [15:0] lv);
    longint y, yb, f, zz, p;
    int n, sh;
    y  = longint'(lv) * LOG2E;
    yb = y + (64'sd16 <<< 42);
    n  = int'(yb >>> 42) - 16;
    f  = (yb >>> 12) & (ONE_Q30 - 1);
    zz = (f * LN2) >>> 30;
    p  = ONE_Q30;
    for (int k = 10; k >= 1; k--)
      p = ONE_Q30 + ((zz * p) >>> 30) / k;
    sh = n - 10;
    return sh >= 0 ? (p <<< sh) : (p >>> (-sh));
  endfunction

  function automatic longint rot_entry(input longint a, input longint n2);
    longint q;
    q = ((mag(a) <<< 30) + n2 / 2) / n2;
    return a < 0 ? -q : q;
  endfunction

  function automatic logic signed [47:0] sat_round(input longint acc);
    longint r;
    r = (mag(acc) + 2048) >>> 12;
    if (acc < 0) begin
      if (r > NEG_SAT) r = NEG_SAT;
      return 48'(-r);
    end
    if (r > POS_SAT) r = POS_SAT;
    return 48'(r);
  endfunction

  function automatic cov_t predict_cov(input splat_t s, input flip_t fl);
    longint w, x, y, z, n2, w2, x2, y2, z2, acc, mm;
    longint rot[3][3];
    longint m[3][3];
    longint sc[3];
    logic [5:0][47:0] res;
    int ra[6], cb[6];
    ra = '{0, 0, 0, 1, 1, 2};
    cb = '{0, 1, 2, 1, 2, 2};
    w = s.quat_w;
    x = fl.qx ? -longint'(s.quat_x) : longint'(s.quat_x);
    y = fl.qy ? -longint'(s.quat_y) : longint'(s.quat_y);
    z = fl.qz ? -longint'(s.quat_z) : longint'(s.quat_z);
    w2 = w * w; x2 = x * x; y2 = y * y; z2 = z * z;
    n2 = w2 + x2 + y2 + z2;
    if (n2 == 0) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          rot[i][j] = (i == j) ? ONE_Q30 : 0;
    end else begin
      rot[0][0] = rot_entry(w2 + x2 - y2 - z2, n2);
      rot[0][1] = rot_entry(2 * (x * y - w * z), n2);
      rot[0][2] = rot_entry(2 * (x * z + w * y), n2);
      rot[1][0] = rot_entry(2 * (x * y + w * z), n2);
      rot[1][1] = rot_entry(w2 - x2 + y2 - z2, n2);
      rot[1][2] = rot_entry(2 * (y * z - w * x), n2);
      rot[2][0] = rot_entry(2 * (x * z - w * y), n2);
      rot[2][1] = rot_entry(2 * (y * z + w * x), n2);
      rot[2][2] = rot_entry(w2 - x2 - y2 + z2, n2);
    end
    sc[0] = exp_scale(s.log_scale_x);
    sc[1] = exp_scale(s.log_scale_y);
    sc[2] = exp_scale(s.log_scale_z);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        mm = (mag(rot[i][j]) * sc[j] + (64'sd1 <<< 31)) >>> 32;
        m[i][j] = rot[i][j] < 0 ? -mm : mm;
      end
    // cov_xx sits in the top slice of the packed result
    for (int e = 0; e < 6; e++) begin
      acc = m[ra[e]][0] * m[cb[e]][0] + m[ra[e]][1] * m[cb[e]][1]
          + m[ra[e]][2] * m[cb[e]][2];
      res[5 - e] = sat_round(acc);
    end
    return cov_t'(res);
  endfunction

  assign pending = cov_q.size();

  always @(posedge clk) begin
    cov_t exp_c;
    logic [5:0][47:0] ev, av;
    string names[6];
    bit bad;
    names = '{"cov_xx", "cov_xy", "cov_xz", "cov_yy", "cov_yz", "cov_zz"};
    if (rst) begin
      flips  <= '{qx: 1'b0, qy: 1'b1, qz: 1'b1};
      cov_q.delete();
      errors <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_NEGATE_QX: flips.qx <= pwdata[0];
          REG_NEGATE_QY: flips.qy <= pwdata[0];
          REG_NEGATE_QZ: flips.qz <= pwdata[0];
          default: ;
        endcase
      end
      if (splat_valid && !splat_stall)
        cov_q.insert(cov_q.size(), predict_cov(splat, flips));
      if (cov_valid && !cov_stall) begin
        if (cov_q.size() == 0) begin
          if (errors < 10)
            $display("unexpected covariance request: %h", cov);
          errors <= errors + 1;
        end else begin
          exp_c = cov_q.pop_front();
          ev = exp_c;
          av = cov;
          bad = 0;
          for (int e = 0; e < 6; e++)
            if (ev[5 - e] !== av[5 - e]) begin
              bad = 1;
              if (errors < 10)
                $display("%s mismatch: expected %h got %h", names[e], ev[5 - e], av[5 - e]);
            end
          if (bad) errors <= errors + 1;
        end
      end
    end
  end
endmodule

@@ bench/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spc_pkg::*;

  logic clk, rst;
  logic splat_valid, splat_stall, cov_valid, cov_stall;
  splat_t splat;
  cov_t cov;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  int errors, pending;
  int snd_idle, rcv_idle;
  bit hold_off;

  gaussian_splat_covariance u_top (.*);

  cov_checker u_chk (
    .clk, .rst, .splat_valid, .splat_stall, .splat, .cov_valid, .cov_stall, .cov,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .errors, .pending
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8ms;
    $display("gaussian_splat_covariance verification failed");
    $finish;
  end

  always @(posedge clk)
    cov_stall <= hold_off || ($urandom_range(99) < rcv_idle);

  task automatic reg_write(input logic [1:0] idx, input logic val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= {31'd0, val};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // valid stays high between back-to-back requests; drop it only for a gap
  task automatic send_splat(input splat_t s);
    if ($urandom_range(99) < snd_idle) begin
      splat_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < snd_idle) @(posedge clk);
    end
    splat <= s;
    splat_valid <= 1;
    do @(posedge clk); while (splat_stall);
  endtask

  task automatic drain();
    splat_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [15:0] pick16(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(1, 0) ? 16'h7fff : 16'h8000);
      2: return 16'($signed($urandom_range(16384)) - 8192);
      default: return 16'($signed($urandom_range(24000)) - 12000);
    endcase
  endfunction

  function automatic splat_t rand_splat();
    splat_t s;
    int sm, qm;
    sm = $urandom_range(9) < 7 ? 2 : $urandom_range(3);
    qm = $urandom_range(9) < 6 ? 3 : $urandom_range(3);
    s.log_scale_x = pick16(sm);
    s.log_scale_y = pick16(sm);
    s.log_scale_z = pick16(sm);
    s.quat_w = pick16(qm);
    s.quat_x = pick16(qm);
    s.quat_y = pick16(qm);
    s.quat_z = pick16(qm);
    if ($urandom_range(40) == 0) {s.quat_w, s.quat_x, s.quat_y, s.quat_z} = '0;
    return s;
  endfunction

  initial begin
    splat_t d[$];
    logic [15:0] ext[4];
    ext = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    rst = 1; splat_valid = 0; splat = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    snd_idle = 0; rcv_idle = 0; hold_off = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // zero quaternion, identity, each axis, scale extremes
    d.insert(d.size(), '{0, 0, 0, 0, 0, 0, 0});
    d.insert(d.size(), '{0, 0, 0, 16'h4000, 0, 0, 0});
    d.insert(d.size(), '{0, 0, 0, 0, 16'h4000, 0, 0});
    d.insert(d.size(), '{0, 0, 0, 0, 0, 16'h4000, 0});
    d.insert(d.size(), '{0, 0, 0, 0, 0, 0, 16'h4000});
    d.insert(d.size(), '{16'h1000, 16'hf000, 16'h0800, 16'h2d41, 16'h2d41, 0, 0});
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        d.insert(d.size(), '{ext[i], ext[j], ext[(i + j) % 4], ext[j], ext[i],
                             ext[3 - j], ext[3 - i]});
    d.insert(d.size(),
             '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
    foreach (d[k]) send_splat(d[k]);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin reg_write(REG_NEGATE_QX, 1); reg_write(REG_NEGATE_QY, 1);
                 reg_write(REG_NEGATE_QZ, 1); end
        1: begin reg_write(REG_NEGATE_QX, 0); reg_write(REG_NEGATE_QY, 0);
                 reg_write(REG_NEGATE_QZ, 0); end
        2: begin reg_write(REG_NEGATE_QX, 0); reg_write(REG_NEGATE_QY, 1);
                 reg_write(REG_NEGATE_QZ, 1); end
        default: begin
          reg_write(REG_NEGATE_QX, 1'($urandom));
          reg_write(REG_NEGATE_QY, 1'($urandom));
          reg_write(REG_NEGATE_QZ, 1'($urandom));
        end
      endcase
      case (ph / 2)
        0: begin snd_idle = 12; rcv_idle = 76; end
        1: begin snd_idle = 76; rcv_idle = 12; end
        default: begin snd_idle = 0; rcv_idle = 0; end
      endcase
      if (ph == 5)
        fork
          begin
            hold_off <= 1;
            repeat (300) @(posedge clk);
            hold_off <= 0;
          end
        join_none
      for (int k = 0; k < 205; k++) send_splat(rand_splat());
      drain();
    end

    if (errors == 0)
      $display("gaussian_splat_covariance verification clean");
    else
      $display("gaussian_splat_covariance verification failed");
    $finish;
  end
endmodule

@@ filelist.f @@
design/spc_pkg.sv
design/spc_exp.sv
design/spc_rot.sv
design/spc_cov.sv
design/gaussian_splat_covariance.sv
design/spc_chk.sv
bench/cov_checker.sv
bench/tb.sv
